// ----- hw/rtl/sla_pkg.sv -----
// ============================================================================
// sla_pkg
// Shared types, constants and the quarter-wave sine table of the stereo
// tremolo block.
// ============================================================================
package sla_pkg;

   // Sample width default and fixed-point constants
   localparam int SAMPLE_BITS_DEF  = 24;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int QTAB_SIZE        = SINE_TABLE_DEPTH / 4;
   localparam int QTAB_BITS        = $clog2(QTAB_SIZE);
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int CSR_ADDR_BITS    = 5;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Reciprocals for the constant divisions, scaled by 2^36 and rounded down
   localparam logic [31:0] RECIP_254 = 32'd270549121;
   localparam logic [31:0] RECIP_18  = 32'd3817748707;
   localparam int          RECIP_SHIFT = 36;

   // Wave shape codes
   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_PULSE    = 3'd1;
   localparam logic [2:0] WAVE_TRI      = 3'd2;
   localparam logic [2:0] WAVE_RAMP     = 3'd3;
   localparam logic [2:0] WAVE_INV_SAW  = 3'd4;

   // Register map
   typedef enum logic [2:0] {
      CSR_PHASE_STEP   = 3'd0,
      CSR_WAVE_SHAPE   = 3'd1,
      CSR_WAVE_POWER   = 3'd2,
      CSR_FLOOR_LEVEL  = 3'd3,
      CSR_STEREO_PHASE = 3'd4,
      CSR_SLUR         = 3'd5,
      CSR_GAIN         = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [2:0]  wave_shape;
      logic [3:0]  wave_power;
      logic [7:0]  floor_level;
      logic [11:0] stereo_phase;
      logic [7:0]  slur;
      logic [7:0]  gain;
   } sla_cfg_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_OSC,
      OP_SQR,
      OP_NUMA,
      OP_DIVM,
      OP_DIVF,
      OP_NUMB,
      OP_NUMC1,
      OP_NUMC2,
      OP_SCALE,
      OP_SAT,
      OP_LOAD
   } sla_op_type;

   typedef struct packed {
      sla_op_type op;
      logic       chan;    // 0 left, 1 right
      logic       div18;   // divide by 18 instead of 254
   } sla_cmd_type;

   // sin(r * pi/2 / 2^30) in Q30 by a short Taylor series
   function automatic logic [63:0] quarter_sine(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      return (x * t) >> 30;
   endfunction

   // Entry k-1 holds the clamped quarter sine at k/QTAB_SIZE of a quarter cycle
   typedef logic [30:0] qsine_tab_type [QTAB_SIZE];

   function automatic qsine_tab_type qsine_build();
      qsine_tab_type tab;
      logic [63:0]   s;
      for (int k = 1; k <= QTAB_SIZE; k++) begin
         s = quarter_sine(64'(k) << (30 - QTAB_BITS));
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         tab[k-1] = s[30:0];
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE_TAB = qsine_build();

endpackage

// ----- hw/rtl/sla_if.sv -----
// ============================================================================
// sla_req_if / sla_rsp_if
// Request and result channels with valid/ready handshake.
// ============================================================================
interface sla_req_if #(
   parameter int SAMPLE_BITS = sla_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic                          restart_phase;

   modport source (output valid, output left_in, output right_in,
                   output restart_phase, input ready);
   modport sink   (input valid, input left_in, input right_in,
                   input restart_phase, output ready);
endinterface

interface sla_rsp_if #(
   parameter int SAMPLE_BITS = sla_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- hw/rtl/sla_csr.sv -----
// ============================================================================
// sla_csr
// Configuration registers behind an APB-style write/read port.
// ============================================================================
module sla_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sla_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output sla_pkg::sla_cfg_type               cfg
);
   import sla_pkg::*;

   sla_cfg_type   cfg_ff;
   sla_cfg_type   cfg_in;
   csr_index_type idx;
   logic          wr_en;

   assign idx    = csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_PHASE_STEP:   cfg_in.phase_step   = pwdata;
            CSR_WAVE_SHAPE:   cfg_in.wave_shape   = pwdata[2:0];
            CSR_WAVE_POWER:   cfg_in.wave_power   = pwdata[3:0];
            CSR_FLOOR_LEVEL:  cfg_in.floor_level  = pwdata[7:0];
            CSR_STEREO_PHASE: cfg_in.stereo_phase = pwdata[11:0];
            CSR_SLUR:         cfg_in.slur         = pwdata[7:0];
            CSR_GAIN:         cfg_in.gain         = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step   <= 32'd97391;
         cfg_ff.wave_shape   <= WAVE_SINE;
         cfg_ff.wave_power   <= 4'd1;
         cfg_ff.floor_level  <= 8'd0;
         cfg_ff.stereo_phase <= 12'd1024;
         cfg_ff.slur         <= 8'd242;
         cfg_ff.gain         <= 8'd18;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         CSR_PHASE_STEP:   prdata = cfg_ff.phase_step;
         CSR_WAVE_SHAPE:   prdata = {29'd0, cfg_ff.wave_shape};
         CSR_WAVE_POWER:   prdata = {28'd0, cfg_ff.wave_power};
         CSR_FLOOR_LEVEL:  prdata = {24'd0, cfg_ff.floor_level};
         CSR_STEREO_PHASE: prdata = {20'd0, cfg_ff.stereo_phase};
         CSR_SLUR:         prdata = {24'd0, cfg_ff.slur};
         CSR_GAIN:         prdata = {24'd0, cfg_ff.gain};
         default:          prdata = 32'd0;
      endcase
   end

endmodule

// ----- hw/rtl/sla_ctrl.sv -----
// ============================================================================
// sla_ctrl
// Sequencer: steps the datapath through oscillator, squaring, floor, gain,
// slur and scaling for the left then the right channel.
// ============================================================================
module sla_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  sla_pkg::sla_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sla_pkg::sla_cmd_type cmd
);
   import sla_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OSC, ST_SQR, ST_NUMA, ST_DIVM, ST_DIVF, ST_NUMB,
      ST_NUMC1, ST_NUMC2, ST_SCALE, ST_SAT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {DIV_A, DIV_B, DIV_C} div_stage_type;

   state_type     state_ff, state_in;
   div_stage_type stage_ff, stage_in;
   logic          chan_ff, chan_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          load_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Command for the current step
   always_comb begin
      cmd.chan  = chan_ff;
      cmd.div18 = (stage_ff == DIV_B);
      case (state_ff)
         ST_IDLE:  cmd.op = accept ? OP_START : OP_NONE;
         ST_OSC:   cmd.op = OP_OSC;
         ST_SQR:   cmd.op = OP_SQR;
         ST_NUMA:  cmd.op = OP_NUMA;
         ST_DIVM:  cmd.op = OP_DIVM;
         ST_DIVF:  cmd.op = OP_DIVF;
         ST_NUMB:  cmd.op = OP_NUMB;
         ST_NUMC1: cmd.op = OP_NUMC1;
         ST_NUMC2: cmd.op = OP_NUMC2;
         ST_SCALE: cmd.op = OP_SCALE;
         ST_SAT:   cmd.op = OP_SAT;
         ST_DONE:  cmd.op = load_ok ? OP_LOAD : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      chan_in      = chan_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_OSC;
               chan_in  = 1'b0;
            end
         end
         ST_OSC: begin
            cnt_in = cfg.wave_power - 4'd1;
            if (cfg.wave_shape == WAVE_PULSE || cfg.wave_power < 4'd2) begin
               state_in = ST_NUMA;
            end else begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               state_in = ST_NUMA;
            end
         end
         ST_NUMA: begin
            state_in = ST_DIVM;
            stage_in = DIV_A;
         end
         ST_DIVM: state_in = ST_DIVF;
         ST_DIVF: begin
            case (stage_ff)
               DIV_A:   state_in = ST_NUMB;
               DIV_B:   state_in = ST_NUMC1;
               default: state_in = ST_SCALE;
            endcase
         end
         ST_NUMB: begin
            state_in = ST_DIVM;
            stage_in = DIV_B;
         end
         ST_NUMC1: state_in = ST_NUMC2;
         ST_NUMC2: begin
            state_in = ST_DIVM;
            stage_in = DIV_C;
         end
         ST_SCALE: state_in = ST_SAT;
         ST_SAT: begin
            if (!chan_ff) begin
               chan_in  = 1'b1;
               state_in = ST_OSC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= DIV_A;
         chan_ff      <= 1'b0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         chan_ff      <= chan_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/sla_dp.sv -----
// ============================================================================
// sla_dp
// Datapath: phase accumulator, oscillator, one shared multiplier with its
// post-processing, slur state and result registers.
// ============================================================================
module sla_dp #(
   parameter int SAMPLE_BITS = sla_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sla_pkg::sla_cfg_type          cfg,
   input  sla_pkg::sla_cmd_type          cmd,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   input  logic                          restart_phase,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out
);
   import sla_pkg::*;

   localparam int PW = SAMPLE_BITS + 25;   // rounded scale product
   localparam int SW = SAMPLE_BITS + 5;    // product after the Q20 shift

   logic        [31:0]            phase_ff, phase_in;
   logic        [20:0]            u_ff, u_in;
   logic        [31:0]            num_ff, num_in;
   logic        [27:0]            q_ff, q_in;
   logic        [23:0]            val_ff, val_in;
   logic        [23:0]            prev_ff [2];
   logic        [23:0]            prev_in [2];
   logic signed [PW-1:0]          sprod_ff, sprod_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff [2];
   logic signed [SAMPLE_BITS-1:0] smp_in [2];
   logic signed [SAMPLE_BITS-1:0] res_ff [2];
   logic signed [SAMPLE_BITS-1:0] res_in [2];
   logic signed [SAMPLE_BITS-1:0] out_ff [2];
   logic signed [SAMPLE_BITS-1:0] out_in [2];

   logic [7:0]  fl, sl;
   logic [11:0] sp;
   logic [31:0] off, ph;
   logic [19:0] g;
   logic [1:0]  quad;
   logic [QTAB_BITS:0]   k;
   logic [QTAB_BITS-1:0] tidx;
   logic [30:0] s;
   logic [31:0] v;
   logic [20:0] vr;
   logic [20:0] osc_u;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic        [35:0] qd, rem;
   logic        [35:0] div_c;
   logic signed [SW-1:0] sh;

   // Clamp the configuration codes
   assign fl  = (cfg.floor_level > 8'd254) ? 8'd254 : cfg.floor_level;
   assign sl  = (cfg.slur > 8'd254) ? 8'd254 : cfg.slur;
   assign sp  = (cfg.stereo_phase > 12'd2048) ? 12'd2048 : cfg.stereo_phase;
   assign off = {sp - 12'd1024, 20'd0};

   // Oscillator: channel phase, then sine table or piecewise-linear wave
   always_comb begin
      ph = cmd.chan ? (phase_ff + off) : (phase_ff - off);
      if (cfg.wave_shape inside {[WAVE_PULSE:WAVE_INV_SAW]}) begin
         ph = ph + 32'h4000_0000;
      end
      g    = ph[31:12];
      quad = ph[31:30];
      k    = quad[0] ? ((QTAB_BITS+1)'(QTAB_SIZE) - {1'b0, ph[29:30-QTAB_BITS]})
                     : {1'b0, ph[29:30-QTAB_BITS]};
      tidx = QTAB_BITS'(k - (QTAB_BITS+1)'(1));
      s    = (k == '0) ? 31'd0 : QSINE_TAB[tidx];
      v    = quad[1] ? (32'h4000_0000 - {1'b0, s}) : (32'h4000_0000 + {1'b0, s});
      vr   = 21'((v + 32'd1024) >> 11);
      case (cfg.wave_shape)
         WAVE_PULSE:    osc_u = g[19] ? 21'h10_0000 : 21'd0;
         WAVE_TRI:      osc_u = g[19] ? (21'h20_0000 - {g, 1'b0}) : {g, 1'b0};
         WAVE_RAMP:     osc_u = {1'b0, g};
         WAVE_INV_SAW:  osc_u = 21'h10_0000 - {1'b0, g};
         default:       osc_u = (vr > 21'h0F_FFFF) ? 21'h0F_FFFF : vr;
      endcase
   end

   // Shared multiplier operand select
   always_comb begin
      case (cmd.op)
         OP_SQR: begin
            mul_a = 33'(u_ff);
            mul_b = 33'(u_ff);
         end
         OP_NUMA: begin
            mul_a = 33'(u_ff);
            mul_b = 33'(8'd254 - fl);
         end
         OP_DIVM: begin
            mul_a = 33'(num_ff);
            mul_b = 33'(cmd.div18 ? RECIP_18 : RECIP_254);
         end
         OP_NUMB: begin
            mul_a = 33'(val_ff);
            mul_b = 33'(cfg.gain);
         end
         OP_NUMC1: begin
            mul_a = 33'(val_ff);
            mul_b = 33'(8'd254 - sl);
         end
         OP_NUMC2: begin
            mul_a = 33'(prev_ff[cmd.chan]);
            mul_b = 33'(sl);
         end
         OP_SCALE: begin
            mul_a = 33'(smp_ff[cmd.chan]);
            mul_b = 33'(val_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Quotient correction: remainder against the divisor
   assign qd    = cmd.div18 ? ((36'(q_ff) << 4) + (36'(q_ff) << 1))
                            : ((36'(q_ff) << 8) - (36'(q_ff) << 1));
   assign div_c = cmd.div18 ? 36'd18 : 36'd254;
   assign rem   = 36'(num_ff) - qd;
   assign sh    = SW'(sprod_ff >>> 20);

   // Register updates per operation
   always_comb begin
      phase_in = phase_ff;
      u_in     = u_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      val_in   = val_ff;
      sprod_in = sprod_ff;
      prev_in  = prev_ff;
      smp_in   = smp_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      case (cmd.op)
         OP_START: begin
            smp_in[0] = left_in;
            smp_in[1] = right_in;
            if (restart_phase) begin
               phase_in = 32'd0;
            end
         end
         OP_OSC:   u_in   = osc_u;
         OP_SQR:   u_in   = 21'((prod[41:0] + 42'd524288) >> 20);
         OP_NUMA:  num_in = prod[31:0] + {4'd0, fl, 20'd0} + 32'd127;
         OP_DIVM:  q_in   = prod[63:36];
         OP_DIVF:  val_in = (rem >= div_c) ? 24'(q_ff + 28'd1) : 24'(q_ff);
         OP_NUMB:  num_in = prod[31:0] + 32'd9;
         OP_NUMC1: num_in = prod[31:0] + 32'd127;
         OP_NUMC2: num_in = num_ff + prod[31:0];
         OP_SCALE: begin
            sprod_in              = PW'(prod) + PW'(524288);
            prev_in[cmd.chan]     = val_ff;
         end
         OP_SAT: begin
            if (sh[SW-1:SAMPLE_BITS-1] == '0 || sh[SW-1:SAMPLE_BITS-1] == '1) begin
               res_in[cmd.chan] = sh[SAMPLE_BITS-1:0];
            end else if (sh[SW-1]) begin
               res_in[cmd.chan] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
               res_in[cmd.chan] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
         end
         OP_LOAD: begin
            out_in   = res_ff;
            phase_in = phase_ff + cfg.phase_step;
         end
         default: phase_in = phase_ff;
      endcase
   end

   // State with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 32'd0;
         prev_ff[0] <= 24'h10_0000;
         prev_ff[1] <= 24'h10_0000;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      num_ff   <= num_in;
      q_ff     <= q_in;
      val_ff   <= val_in;
      sprod_ff <= sprod_in;
      smp_ff   <= smp_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign left_out  = out_ff[0];
   assign right_out = out_ff[1];

endmodule

// ----- hw/rtl/stereo_lfo_amplitude_modulator.sv -----
// ============================================================================
// stereo_lfo_amplitude_modulator
// Stereo tremolo: each sample pair is scaled by a per-channel LFO factor.
// ============================================================================
// Usage:
//   req_ch carries one stereo pair (left_in, right_in) and restart_phase;
//   a request is taken when valid and ready are both high. rsp_ch returns
//   the modulated pair, saturated to SAMPLE_BITS.
//   The csr_ port writes the seven LFO registers at 4*index; write them only
//   while no request is in flight.
//   Only one request is in flight: a new one is taken only in idle, after
//   the previous result was loaded. Each channel does wave_power-1
//   squarings (none below two or for square) on the single shared
//   multiplier, walking oscillator, squarings, floor, gain, slur and scale
//   steps through it, left then right. The output pair and rsp_ch.valid
//   are registered in the done step after the right channel's saturation.
//   Reset clears the phase, sets both smoothing factors to 1.0 and loads the
//   register defaults. When the receiver stalls, the finished pair holds in
//   the output register; the next request is still taken and computed, and
//   waits in its final step until the output register frees up.
// ============================================================================
module stereo_lfo_amplitude_modulator #(
   parameter int SAMPLE_BITS = sla_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   sla_req_if.sink                           req_ch,
   sla_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sla_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import sla_pkg::*;

   sla_cfg_type cfg;
   sla_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   // Register file
   sla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Sequencer
   sla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Arithmetic
   sla_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .left_in       (req_ch.left_in),
      .right_in      (req_ch.right_in),
      .restart_phase (req_ch.restart_phase),
      .left_out      (rsp_ch.left_out),
      .right_out     (rsp_ch.right_out)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   // A taken request blocks the input until its result is out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while previous one in progress");

   // Never overwrite a result that the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending result overwritten");

   // Input samples are latched only on a handshake
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_START |-> (req_ch.valid && req_ch.ready))
      else $error("start issued without request");

   // A result becomes valid only after the load step
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.op == OP_LOAD))
      else $error("result valid without load");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Stereo tremolo block testbench
// Drives stereo sample pairs through the request channel and predicts each
// modulated pair with a local fixed-point tremolo model. The model covers the
// phase accumulator, the wave shapes, the squaring chain, floor, gain and slur.
// Registers are rewritten through the csr_ port between phases. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sla_pkg::*;

   localparam logic [31:0] Q20_UNIT  = 32'd1048576;
   localparam logic [63:0] Q30_UNIT  = 64'd1073741824;
   localparam logic [63:0] HALF_PI30 = 64'd1686629713;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          DRAIN_CYCLES = 64;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } stereo_pair_type;

   logic clock;
   logic reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]       csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   sla_req_if req_ch ();
   sla_rsp_if rsp_ch ();

   stereo_lfo_amplitude_modulator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the register file and the tremolo state
   logic [31:0] step_reg;
   logic [2:0]  shape_reg;
   logic [3:0]  power_reg;
   logic [7:0]  floor_reg;
   logic [11:0] spread_reg;
   logic [7:0]  slur_reg;
   logic [7:0]  gain_reg;
   logic [31:0] lfo_phase;
   logic [31:0] left_factor;
   logic [31:0] right_factor;
   logic [19:0] sine_rom [1024];

   stereo_pair_type expected_pairs[$];
   int              error_count;
   int              cycle_count;
   int              burst_left;
   int              stall_pct;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sin(r * pi/2 / 2^30) in Q30 by a truncated series
   function automatic logic [63:0] qsin30(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] divisors [6];
      divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      x  = (r * HALF_PI30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_UNIT;
      for (int k = 0; k < 6; k++) begin
         t = Q30_UNIT - ((x2 * t) >> 30) / divisors[k];
      end
      return (x * t) >> 30;
   endfunction

   function automatic logic [19:0] sine_entry(input logic [31:0] p);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] v;
      quad = p[31:30];
      r    = {34'd0, p[29:0]};
      if (quad[0]) begin
         r = Q30_UNIT - r;
      end
      s = qsin30(r);
      if (s > Q30_UNIT) begin
         s = Q30_UNIT;
      end
      v = quad[1] ? (Q30_UNIT - s) : (Q30_UNIT + s);
      v = (v + 64'd1024) >> 11;
      if (v > 64'(Q20_UNIT) - 1) begin
         v = 64'(Q20_UNIT) - 1;
      end
      return v[19:0];
   endfunction

   // Oscillator value in Q1.20 for one channel phase
   function automatic logic [63:0] lfo_value(input logic [31:0] ph);
      logic [31:0] shifted;
      logic [63:0] g;
      if (shape_reg == WAVE_SINE || shape_reg > WAVE_INV_SAW) begin
         return {44'd0, sine_rom[ph[31:22]]};
      end
      shifted = ph + 32'h4000_0000;
      g       = {44'd0, shifted[31:12]};
      case (shape_reg)
         WAVE_PULSE: begin
            return (g < 64'd524288) ? 64'd0 : 64'(Q20_UNIT);
         end
         WAVE_TRI: begin
            return (g < 64'd524288) ? 2 * g : 2 * 64'(Q20_UNIT) - 2 * g;
         end
         WAVE_RAMP: begin
            return g;
         end
         default: begin
            return 64'(Q20_UNIT) - g;
         end
      endcase
   endfunction

   function automatic logic [31:0] smoothed_factor(input logic [31:0] ph,
                                                   input logic [31:0] prev);
      logic [63:0] u;
      logic [63:0] fl;
      logic [63:0] sl;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      fl = (floor_reg > 8'd254) ? 64'd254 : 64'(floor_reg);
      sl = (slur_reg > 8'd254) ? 64'd254 : 64'(slur_reg);
      u  = lfo_value(ph);
      if (shape_reg != WAVE_PULSE) begin
         for (int p = 1; p < power_reg; p++) begin
            u = (u * u + 64'd524288) >> 20;
         end
      end
      a = (u * (64'd254 - fl) + fl * 64'(Q20_UNIT) + 64'd127) / 64'd254;
      b = (a * 64'(gain_reg) + 64'd9) / 64'd18;
      c = ((64'd254 - sl) * b + sl * 64'(prev) + 64'd127) / 64'd254;
      return c[31:0];
   endfunction

   function automatic logic signed [23:0] apply_factor(input logic signed [23:0] x,
                                                       input logic [31:0] factor);
      logic signed [63:0] n;
      logic signed [63:0] r;
      n = 64'(x) * $signed({32'd0, factor}) + 64'sd524288;
      r = n >>> 20;
      if (r > 64'sd8388607) begin
         r = 64'sd8388607;
      end
      if (r < -64'sd8388608) begin
         r = -64'sd8388608;
      end
      return r[23:0];
   endfunction

   // Advance the tremolo state by one accepted request and queue its result
   task automatic predict_pair(input logic signed [23:0] l, input logic signed [23:0] r,
                               input logic restart);
      logic [31:0]     spread;
      logic [31:0]     offset;
      stereo_pair_type pair;
      spread = (spread_reg > 12'd2048) ? 32'd2048 : 32'(spread_reg);
      offset = (spread << 20) - (32'd1024 << 20);
      if (restart) begin
         lfo_phase = '0;
      end
      left_factor  = smoothed_factor(lfo_phase - offset, left_factor);
      right_factor = smoothed_factor(lfo_phase + offset, right_factor);
      pair.left    = apply_factor(l, left_factor);
      pair.right   = apply_factor(r, right_factor);
      expected_pairs.push_back(pair);
      lfo_phase = lfo_phase + step_reg;
   endtask

   // Register write: setup cycle, then access cycle
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_PHASE_STEP:   step_reg   = value;
         CSR_WAVE_SHAPE:   shape_reg  = value[2:0];
         CSR_WAVE_POWER:   power_reg  = value[3:0];
         CSR_FLOOR_LEVEL:  floor_reg  = value[7:0];
         CSR_STEREO_PHASE: spread_reg = value[11:0];
         CSR_SLUR:         slur_reg   = value[7:0];
         CSR_GAIN:         gain_reg   = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] step, input logic [2:0] shape,
                            input logic [3:0] power, input logic [7:0] fl,
                            input logic [11:0] spread, input logic [7:0] sl,
                            input logic [7:0] gn);
      csr_write(CSR_PHASE_STEP, step);
      csr_write(CSR_WAVE_SHAPE, 32'(shape));
      csr_write(CSR_WAVE_POWER, 32'(power));
      csr_write(CSR_FLOOR_LEVEL, 32'(fl));
      csr_write(CSR_STEREO_PHASE, 32'(spread));
      csr_write(CSR_SLUR, 32'(sl));
      csr_write(CSR_GAIN, 32'(gn));
   endtask

   // Send one request, in bursts with random gaps between them
   task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r,
                            input logic restart);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.left_in       <= l;
      req_ch.right_in      <= r;
      req_ch.restart_phase <= restart;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      predict_pair(l, r, restart);
      burst_left--;
   endtask

   // Drop valid and wait until every pair is back and the block is idle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_pairs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'($urandom);
      endcase
   endfunction

   // Extremes of the samples and restart under reset register values
   task automatic test_reset_defaults();
      send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      send_pair(24'sh800000, 24'sh7FFFFF, 1'b1);
      send_pair(24'sh000000, 24'shFFFFFF, 1'b0);
      send_pair(24'sh555555, 24'shAAAAAA, 1'b0);
      drain();
   endtask

   // Every wave code, unused codes included
   task automatic test_wave_shapes();
      for (int s = 0; s < 8; s++) begin
         write_all(32'h1000_0000, 3'(s), 4'd2, 8'd0, 12'd1536, 8'd0, 8'd18);
         send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
         send_pair(24'sh400000, 24'shC00000, 1'b0);
         drain();
      end
   endtask

   // Power, floor, slur, spread and gain at their extremes and out-of-range codes
   task automatic test_register_extremes();
      write_all(32'hFFFF_FFFF, WAVE_TRI, 4'd15, 8'd255, 12'd4095, 8'd255, 8'd255);
      send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      drain();
      write_all(32'h0000_0000, WAVE_RAMP, 4'd0, 8'd254, 12'd0, 8'd254, 8'd0);
      send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
      drain();
      write_all(32'h0123_4567, WAVE_SINE, 4'd14, 8'd0, 12'd2048, 8'd0, 8'd254);
      send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      send_pair(24'sh123456, 24'sh876543, 1'b0);
      drain();
   endtask

   function automatic logic [7:0] pick_code(input logic [7:0] hi);
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return hi;
         2: return 8'd255;
         default: return 8'($urandom_range(0, hi));
      endcase
   endfunction

   // Random register settings per phase, random pairs within
   task automatic test_random_phases();
      logic [31:0] step;
      int          count;
      for (int ph = 0; ph < 13; ph++) begin
         case ($urandom_range(0, 4))
            0: step = 32'hFFFF_FFFF;
            1: step = 32'($urandom_range(0, 16777215));
            2: step = 32'($urandom_range(0, 4)) << 28;
            default: step = $urandom;
         endcase
         write_all(step, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                   pick_code(8'd254),
                   ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2048)),
                   pick_code(8'd254), pick_code(8'd254));
         count = $urandom_range(35, 65);
         for (int n = 0; n < count; n++) begin
            send_pair(random_sample(), random_sample(), $urandom_range(0, 9) == 0);
         end
         drain();
      end
   endtask

   // Result check and receiver stall pattern
   always @(posedge clock) begin
      stereo_pair_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected result: left_out %0d right_out %0d",
                      rsp_ch.left_out, rsp_ch.right_out);
               error_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_ch.left_out !== want.left) begin
                  $error("left_out expected %0d actual %0d", want.left, rsp_ch.left_out);
                  error_count++;
               end
               if (rsp_ch.right_out !== want.right) begin
                  $error("right_out expected %0d actual %0d", want.right, rsp_ch.right_out);
                  error_count++;
               end
            end
         end
         // change the stall mode
         if (cycle_count % 256 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 30;
               2: stall_pct = 70;
               default: stall_pct = 95;
            endcase
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_ch.valid         = 1'b0;
      req_ch.left_in       = '0;
      req_ch.right_in      = '0;
      req_ch.restart_phase = 1'b0;
      rsp_ch.ready         = 1'b0;
      error_count          = 0;
      cycle_count          = 0;
      burst_left           = 0;
      stall_pct            = 0;
      step_reg             = 32'd97391;
      shape_reg            = WAVE_SINE;
      power_reg            = 4'd1;
      floor_reg            = 8'd0;
      spread_reg           = 12'd1024;
      slur_reg             = 8'd242;
      gain_reg             = 8'd18;
      lfo_phase            = '0;
      left_factor          = Q20_UNIT;
      right_factor         = Q20_UNIT;
      for (int i = 0; i < 1024; i++) begin
         sine_rom[i] = sine_entry(32'(i) << 22);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_wave_shapes();
      test_register_extremes();
      test_random_phases();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
